[rtl/core/ilir_pkg.sv]
package ilir_pkg;

  localparam int unsigned DepthDefault    = 64;
  localparam int unsigned WordBitsDefault = 32;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 7;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } ilir_ctl_t;

endpackage

[rtl/core/ilir_cell.sv]
module ilir_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned POS_W     = 7
) (
  input  logic                   clk_i,
  input  ilir_pkg::ilir_ctl_t    ctl_i,
  input  logic [POS_W-1:0]       pos_i,
  input  logic [WORD_BITS-1:0]   value_i,
  input  logic [WORD_BITS-1:0]   left_i,
  input  logic [WORD_BITS-1:0]   right_i,
  output logic [WORD_BITS-1:0]   q_o,
  output logic [WORD_BITS-1:0]   rd_o
);
  import ilir_pkg::*;

  localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

  logic [WORD_BITS-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (pos_i == MyPos) begin
        entry_d = value_i;
      end else if (pos_i < MyPos) begin
        entry_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (pos_i <= MyPos) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  assign rd_o = (pos_i == MyPos) ? entry_q : '0;

endmodule

[rtl/core/indexed_list_insert_remove.sv]
// Channel   Dir  tdata (low bit up)                     tuser
// s_axis    in   index[6:0], value[38:7], pad[39]       opcode[2:0]
// m_axis    out  read_value[31:0], list_length[38:32],  status[1:0]
//                pad[39]
//
// One transfer per cycle while m_axis takes results: the whole row of cells shifts
// in the cycle of acceptance; the result is in the output register from the next cycle.
// Reset clears the length and the output valid; cell contents are left as they are.
// A result not taken holds in the output register; s_axis_tready then follows
// m_axis_tready.
module indexed_list_insert_remove #(
  parameter int unsigned DEPTH     = ilir_pkg::DepthDefault,
  parameter int unsigned WORD_BITS = ilir_pkg::WordBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ilir_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // index, value, pad
  input  logic [ilir_pkg::OPCODE_W-1:0]   s_axis_tuser,   // opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ilir_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // read_value, list_length, pad
  output logic [ilir_pkg::STATUS_W-1:0]   m_axis_tuser    // status
);
  import ilir_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMPW  = (CW > INDEX_W) ? CW : INDEX_W;

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic [VALUE_W-1:0]   rd_q, rd_d;
  logic [STATUS_W-1:0]  st_q, st_d;
  logic [LEN_W-1:0]     len_q;

  logic                 accept;
  logic [CMPW-1:0]      pos;
  logic [CMPW-1:0]      cnt;
  logic [CMPW-1:0]      cell_pos;
  logic                 full;
  logic                 empty;
  logic [WORD_BITS-1:0] value_word;
  logic [WORD_BITS-1:0] rd_word;
  ilir_ctl_t            ctl;

  logic [WORD_BITS-1:0] cell_q  [DEPTH];
  logic [WORD_BITS-1:0] cell_rd [DEPTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos        = CMPW'(s_axis_tdata[INDEX_W-1:0]);
  assign cnt        = CMPW'(count_q);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign value_word = WORD_BITS'(s_axis_tdata[INDEX_W +: VALUE_W]);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    count_d  = count_q;
    ctl      = '0;
    cell_pos = pos;
    st_d     = ST_OK;
    rd_d     = '0;
    case (s_axis_tuser)
      OP_APPEND: begin
        cell_pos = cnt;
        if (full) begin
          st_d = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos > cnt) begin
          st_d = ST_BADIDX;
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else if (pos > cnt) begin
          st_d = ST_BADIDX;
        end else begin
          ctl.rem = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_READ: begin
        if (pos < cnt) begin
          rd_d = VALUE_W'(rd_word);
        end else begin
          st_d = ST_BADIDX;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl     = '0;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    ilir_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS),
      .POS_W     (CMPW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (cell_pos),
      .value_i (value_word),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      st_q  <= st_d;
      len_q <= LEN_W'(CMPW'(count_d));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, len_q, rd_q};
  assign m_axis_tuser  = st_q;

endmodule
